[rtl/image_border_padder_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef IMAGE_BORDER_PADDER_TOP_ASSERT_SVH
`define IMAGE_BORDER_PADDER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define IBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define IBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ibp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ibp_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_MAX_BORDER = 8;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_APPLY = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ST_READ  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] MODE_EVEN   = 3'd1;
  localparam logic [2:0] MODE_WAVG   = 3'd2;
  localparam logic [2:0] MODE_COPY   = 3'd3;
  localparam logic [2:0] MODE_ODD    = 3'd4;
  localparam logic [2:0] MODE_ZERO   = 3'd5;
  localparam logic [2:0] MODE_WRAP   = 3'd6;
  localparam logic [2:0] MODE_REPEAT = 3'd7;

  localparam logic [1:0] AXES_BOTH = 2'd0;
  localparam logic [1:0] AXES_HOR  = 2'd1;
  localparam logic [1:0] AXES_VER  = 2'd2;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BORDER_WIDTH = 3'd2;
  localparam logic [2:0] REG_PAD_MODE     = 3'd3;
  localparam logic [2:0] REG_PAD_AXES     = 3'd4;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_ODD  = 2'd1,
    ALU_ZERO = 2'd2,
    ALU_AVG  = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic [7:0] frame_width;
    logic [7:0] frame_height;
    logic [3:0] border_width;
    logic [2:0] pad_mode;
    logic [1:0] pad_axes;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/ibp_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
module ibp_alu (
  input  ibp_pkg::alu_op_t    op,
  input  logic signed [15:0]  a_px,
  input  logic signed [15:0]  b_px,
  output logic signed [15:0]  y_px
);
  import ibp_pkg::*;

  logic signed [17:0] odd_sum;
  logic signed [16:0] avg_sum;

  assign odd_sum = {a_px[15], a_px, 1'b0} - {{2{b_px[15]}}, b_px};
  assign avg_sum = {a_px[15], a_px} + {b_px[15], b_px};

  always_comb begin
    unique case (op)
      ALU_PASS: y_px = b_px;
      ALU_ZERO: y_px = '0;
      ALU_AVG:  y_px = avg_sum[16:1];
      ALU_ODD: begin
        if (odd_sum > 18'sd32767) y_px = 16'sh7fff;
        else if (odd_sum < -18'sd32768) y_px = 16'sh8000;
        else y_px = odd_sum[15:0];
      end
      default: y_px = b_px;
    endcase
  end
endmodule
`default_nettype wire

[rtl/ibp_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module ibp_seq #(
  parameter int MAX_WIDTH  = ibp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ibp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BORDER = ibp_pkg::DEF_MAX_BORDER
) (
  input  logic               clk,
  input  logic               rst,
  input  ibp_pkg::cfg_t      cfg,
  input  logic               start,
  input  logic [1:0]         action,
  input  logic signed [8:0]  col,
  input  logic signed [8:0]  row,
  input  logic signed [15:0] pixel_in,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [15:0] res_pixel,
  output logic [1:0]         res_status
);
  import ibp_pkg::*;

  localparam int PITCH  = MAX_WIDTH + 2 * MAX_BORDER;
  localparam int ROWS   = MAX_HEIGHT + 2 * MAX_BORDER;
  localparam int DEPTH  = ROWS * PITCH;
  localparam int AW     = $clog2(DEPTH);
  localparam int MAXDIM = (PITCH > ROWS) ? PITCH : ROWS;
  localparam int CWR    = $clog2(MAXDIM) + 2;
  localparam int CW     = (CWR > 10) ? CWR : 10;
  localparam int MW     = $clog2(MAX_BORDER + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RES  = 13'b0000000000010,
    S_E0   = 13'b0000000000100,
    S_E1   = 13'b0000000001000,
    S_LO   = 13'b0000000010000,
    S_HI   = 13'b0000000100000,
    S_WLO  = 13'b0000001000000,
    S_WHI  = 13'b0000010000000,
    S_A0   = 13'b0000100000000,
    S_A1   = 13'b0001000000000,
    S_A2   = 13'b0010000000000,
    S_AW0  = 13'b0100000000000,
    S_AW1  = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic vert, vert_next;
  logic signed [CW-1:0] j, j_next, jend, jend_next;
  logic [MW-1:0] m, m_next;
  logic [1:0] status, status_next;
  logic signed [15:0] e0r, e1r, lor, hir;

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rdata;
  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic signed [15:0] wdata;

  logic signed [CW-1:0] fw, fh, bw, last, mc, m1, lo_src, hi_src, rpos, wpos;
  logic signed [CW-1:0] icol, irow;
  logic signed [15:0] alu_a, alu_b, alu_y;
  alu_op_t alu_op;
  logic load_ok, read_ok, apply_ok, line_end;

  function automatic logic [AW-1:0] addr_of(input logic signed [CW-1:0] r,
                                             input logic signed [CW-1:0] c);
    logic [CW-1:0] ro, co;
    ro = r + CW'(MAX_BORDER);
    co = c + CW'(MAX_BORDER);
    addr_of = AW'(int'(ro) * PITCH + int'(co));
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    smin = (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    smax = (a > b) ? a : b;
  endfunction

  always_comb begin
    if (cfg.frame_width == '0) fw = CW'(1);
    else if (int'(cfg.frame_width) > MAX_WIDTH) fw = CW'(MAX_WIDTH);
    else fw = CW'({1'b0, cfg.frame_width});
    if (cfg.frame_height == '0) fh = CW'(1);
    else if (int'(cfg.frame_height) > MAX_HEIGHT) fh = CW'(MAX_HEIGHT);
    else fh = CW'({1'b0, cfg.frame_height});
    if (int'(cfg.border_width) > MAX_BORDER) bw = CW'(MAX_BORDER);
    else bw = CW'({1'b0, cfg.border_width});
  end

  assign icol = CW'(col);
  assign irow = CW'(row);
  assign last = vert ? (fh - CW'(1)) : (fw - CW'(1));
  assign mc   = CW'({1'b0, m});
  assign m1   = mc - CW'(1);

  assign load_ok = (icol >= 0) && (icol < fw) && (irow >= 0) && (irow < fh);
  assign read_ok = (icol >= -bw) && (icol < fw + bw) && (irow >= -bw) && (irow < fh + bw);
  assign apply_ok = (cfg.pad_mode != 3'd0) && (cfg.pad_axes != 2'd3) && (bw != '0);
  assign line_end = (j == jend);

  always_comb begin
    lo_src = '0;
    hi_src = '0;
    case (cfg.pad_mode) inside
      MODE_EVEN, MODE_ODD: begin
        lo_src = smin(mc, last);
        hi_src = smax(last - mc, '0);
      end
      MODE_WAVG: begin
        lo_src = smax(last - mc, '0);
        hi_src = smin(mc, last);
      end
      MODE_COPY, MODE_ZERO: begin
        lo_src = '0;
        hi_src = last;
      end
      MODE_WRAP: begin
        lo_src = smax(last - m1, '0);
        hi_src = smin(m1, last);
      end
      MODE_REPEAT: begin
        lo_src = smin(m1, last);
        hi_src = smax(last - m1, '0);
      end
      default: begin
        lo_src = '0;
        hi_src = '0;
      end
    endcase
  end

  always_comb begin
    if (state == S_AW0 || state == S_AW1) alu_op = ALU_AVG;
    else if (cfg.pad_mode == MODE_ODD) alu_op = ALU_ODD;
    else if (cfg.pad_mode == MODE_ZERO) alu_op = ALU_ZERO;
    else alu_op = ALU_PASS;
    alu_a = (state == S_WHI) ? e1r : e0r;
    if (state == S_WLO) alu_b = lor;
    else if (state == S_WHI) alu_b = hir;
    else alu_b = e1r;
  end

  ibp_alu u_alu (
    .op   (alu_op),
    .a_px (alu_a),
    .b_px (alu_b),
    .y_px (alu_y)
  );

  always_comb begin
    state_next  = state;
    vert_next   = vert;
    j_next      = j;
    jend_next   = jend;
    m_next      = m;
    status_next = status;
    re    = 1'b0;
    we    = 1'b0;
    rpos  = '0;
    wpos  = '0;
    raddr = addr_of(vert ? rpos : j, vert ? j : rpos);
    waddr = addr_of(vert ? wpos : j, vert ? j : wpos);
    wdata = alu_y;
    unique case (state)
      S_IDLE: begin
        raddr = addr_of(irow, icol);
        waddr = addr_of(irow, icol);
        wdata = pixel_in;
        if (start) begin
          unique case (action)
            ACT_LOAD: begin
              if (load_ok) begin
                we = 1'b1;
              end else begin
                status_next = ST_RANGE;
                state_next  = S_RES;
              end
            end
            ACT_APPLY: begin
              status_next = ST_APPLY;
              m_next      = MW'(1);
              j_next      = '0;
              if (!apply_ok) begin
                state_next = S_RES;
              end else if (cfg.pad_axes == AXES_VER) begin
                vert_next  = 1'b1;
                jend_next  = fw - CW'(1);
                state_next = S_E0;
              end else begin
                vert_next  = 1'b0;
                jend_next  = fh - CW'(1);
                state_next = S_E0;
              end
            end
            ACT_READ: begin
              re          = read_ok;
              status_next = read_ok ? ST_READ : ST_RANGE;
              state_next  = S_RES;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RES: begin
        if (res_ready) state_next = S_IDLE;
      end
      S_E0, S_A0: begin
        re    = 1'b1;
        rpos  = '0;
        raddr = addr_of(vert ? rpos : j, vert ? j : rpos);
        state_next = (state == S_E0) ? S_E1 : S_A1;
      end
      S_E1, S_A1: begin
        re    = 1'b1;
        rpos  = last;
        raddr = addr_of(vert ? rpos : j, vert ? j : rpos);
        state_next = (state == S_E1) ? S_LO : S_A2;
      end
      S_LO: begin
        re    = 1'b1;
        rpos  = lo_src;
        raddr = addr_of(vert ? rpos : j, vert ? j : rpos);
        state_next = S_HI;
      end
      S_HI: begin
        re    = 1'b1;
        rpos  = hi_src;
        raddr = addr_of(vert ? rpos : j, vert ? j : rpos);
        state_next = S_WLO;
      end
      S_WLO: begin
        we    = 1'b1;
        wpos  = -mc;
        waddr = addr_of(vert ? wpos : j, vert ? j : wpos);
        state_next = S_WHI;
      end
      S_WHI, S_AW1: begin
        we    = 1'b1;
        wpos  = (state == S_WHI) ? (last + mc) : last;
        waddr = addr_of(vert ? wpos : j, vert ? j : wpos);
        if (state == S_WHI && mc != bw) begin
          m_next     = m + MW'(1);
          state_next = S_E0;
        end else if (state == S_WHI && cfg.pad_mode == MODE_WAVG) begin
          state_next = S_A0;
        end else begin
          m_next = MW'(1);
          if (!line_end) begin
            j_next     = j + CW'(1);
            state_next = S_E0;
          end else if (!vert && cfg.pad_axes == AXES_BOTH) begin
            vert_next  = 1'b1;
            j_next     = -bw;
            jend_next  = fw + bw - CW'(1);
            state_next = S_E0;
          end else begin
            state_next = S_RES;
          end
        end
      end
      S_A2: state_next = S_AW0;
      S_AW0: begin
        we    = 1'b1;
        wpos  = '0;
        waddr = addr_of(vert ? wpos : j, vert ? j : wpos);
        state_next = S_AW1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      vert   <= 1'b0;
      j      <= '0;
      jend   <= '0;
      m      <= MW'(1);
      status <= ST_READ;
    end else begin
      state  <= state_next;
      vert   <= vert_next;
      j      <= j_next;
      jend   <= jend_next;
      m      <= m_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_E1 || state == S_A1) e0r <= rdata;
    if (state == S_LO || state == S_A2) e1r <= rdata;
    if (state == S_HI) lor <= rdata;
    if (state == S_WLO) hir <= rdata;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  assign idle       = (state == S_IDLE);
  assign res_valid  = (state == S_RES);
  assign res_status = status;
  assign res_pixel  = (status == ST_READ) ? rdata : 16'sd0;
endmodule
`default_nettype wire

[rtl/image_border_padder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Padded frame store with border fill. A load transfer gives no result unless
// its coordinate is outside the interior. A read returns a result. An apply
// walks every line through one read and one write port of the frame memory:
// for each border pixel pair it reads both line ends and two source pixels,
// then writes the pair; wrap-with-average mode then averages the line ends.
// Passes: frame_height lines horizontally, frame_width (plus 2*border_width
// with corners) lines vertically. The input is not ready during that walk.
module image_border_padder_top #(
  parameter int MAX_WIDTH  = ibp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ibp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BORDER = ibp_pkg::DEF_MAX_BORDER
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // col[8:0], row[17:9], pixel_in[33:18], zero
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pixel_out[15:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ibp_pkg::*;

  cfg_t cfg;
  logic idle, res_valid, res_ready;
  logic signed [15:0] res_pixel;
  logic [1:0] res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 8'd128;
      cfg.frame_height <= 8'd128;
      cfg.border_width <= 4'd1;
      cfg.pad_mode     <= MODE_EVEN;
      cfg.pad_axes     <= AXES_BOTH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        REG_BORDER_WIDTH: cfg.border_width <= cfg_data[3:0];
        REG_PAD_MODE:     cfg.pad_mode     <= cfg_data[2:0];
        REG_PAD_AXES:     cfg.pad_axes     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = idle;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  ibp_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BORDER (MAX_BORDER)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (s_axis_tvalid && s_axis_tready),
    .action     (s_axis_tuser),
    .col        (s_axis_tdata[8:0]),
    .row        (s_axis_tdata[17:9]),
    .pixel_in   (s_axis_tdata[33:18]),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_pixel  (res_pixel),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= res_pixel;
      m_axis_tuser <= res_status;
    end
  end
endmodule
`default_nettype wire

[rtl/image_border_padder_top_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "image_border_padder_top_assert.svh"
module image_border_padder_top_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import ibp_pkg::*;

  `IBP_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `IBP_ASSERT(a_status, m_axis_tvalid |-> m_axis_tuser != 2'd3, "status code out of range")
  `IBP_ASSERT(a_zero, m_axis_tvalid && m_axis_tuser != ST_READ |-> m_axis_tdata == 16'd0, "nonzero pixel on a non-read result")
  `IBP_ASSERT_ALWAYS(a_reset, $past(rst) |-> !m_axis_tvalid, "result valid right after reset")
endmodule

bind image_border_padder_top image_border_padder_top_chk u_chk (.*);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ibp_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int OFS = DEF_MAX_BORDER;
  localparam int DIM = DEF_MAX_WIDTH + 2 * DEF_MAX_BORDER;
  localparam int STALL_LIMIT = 300000;

  typedef struct {
    logic [15:0] px;
    logic [1:0]  st;
  } pad_result_t;

  typedef struct {
    logic [1:0]  act;
    int          c;
    int          r;
    int          p;
    bit          typed;
    int          epx;
    logic [1:0]  est;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  image_border_padder_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0] frame_mem [0:DIM-1][0:DIM-1];
  bit          seen      [0:DIM-1][0:DIM-1];
  logic [7:0]  reg_fw, reg_fh;
  logic [3:0]  reg_bw;
  logic [2:0]  reg_mode;
  logic [1:0]  reg_axes;

  pad_result_t pending[$];
  int errors, items, reads_checked, applies, phases, results_seen;
  bit quiet;
  int stall_left, idle_cycles;

  stim_row_t directed[] = '{
    '{ACT_READ, 200, 0, 0, 1, 0, ST_RANGE},
    '{ACT_LOAD, -1, 0, 5, 1, 0, ST_RANGE},
    '{ACT_LOAD, 128, 0, 5, 1, 0, ST_RANGE},
    '{ACT_LOAD, 0, 128, 5, 1, 0, ST_RANGE},
    '{ACT_LOAD, -256, 255, -1, 1, 0, ST_RANGE},
    '{ACT_LOAD, 255, -256, 0, 1, 0, ST_RANGE},
    '{ACT_LOAD, 0, 0, -32768, 0, 0, ST_READ},
    '{ACT_LOAD, 127, 127, 32767, 0, 0, ST_READ},
    '{ACT_LOAD, 127, 0, -1, 0, 0, ST_READ},
    '{ACT_LOAD, 0, 127, 1, 0, 0, ST_READ},
    '{ACT_READ, 0, 0, 0, 1, -32768, ST_READ},
    '{ACT_READ, 127, 127, 0, 1, 32767, ST_READ},
    '{ACT_READ, 127, 0, 0, 0, 0, ST_READ},
    '{ACT_READ, 0, 127, 0, 0, 0, ST_READ},
    '{ACT_READ, -2, 0, 0, 1, 0, ST_RANGE},
    '{ACT_READ, 0, 129, 0, 1, 0, ST_RANGE},
    '{ACT_NONE, 5, 5, 7, 0, 0, ST_READ},
    '{ACT_READ, -256, -256, 0, 1, 0, ST_RANGE},
    '{ACT_READ, 255, 255, 0, 1, 0, ST_RANGE}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_fw();
    return (reg_fw < 1) ? 1 : (reg_fw > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(reg_fw);
  endfunction

  function automatic int eff_fh();
    return (reg_fh < 1) ? 1 : (reg_fh > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(reg_fh);
  endfunction

  function automatic int eff_bw();
    return (reg_bw > DEF_MAX_BORDER) ? DEF_MAX_BORDER : int'(reg_bw);
  endfunction

  function automatic bit in_store(int r, int c);
    return r >= -OFS && r < DIM - OFS && c >= -OFS && c < DIM - OFS;
  endfunction

  function automatic int line_get(bit vert, int fixed, int pos);
    int r, c;
    r = vert ? pos : fixed;
    c = vert ? fixed : pos;
    if (!in_store(r, c)) return 0;
    return int'($signed(frame_mem[r + OFS][c + OFS]));
  endfunction

  task automatic line_put(bit vert, int fixed, int pos, int v);
    int r, c;
    r = vert ? pos : fixed;
    c = vert ? fixed : pos;
    if (in_store(r, c)) begin
      frame_mem[r + OFS][c + OFS] = v[15:0];
      seen[r + OFS][c + OFS] = 1'b1;
    end
  endtask

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  task automatic pad_line(bit vert, int fixed, int last, int bw, logic [2:0] mode);
    int lo, hi, e0, e1, s;
    for (int m = 1; m <= bw; m++) begin
      e0 = line_get(vert, fixed, 0);
      e1 = line_get(vert, fixed, last);
      case (mode)
        MODE_EVEN: begin
          lo = line_get(vert, fixed, imin(m, last));
          hi = line_get(vert, fixed, imax(last - m, 0));
        end
        MODE_WAVG: begin
          lo = line_get(vert, fixed, imax(last - m, 0));
          hi = line_get(vert, fixed, imin(m, last));
        end
        MODE_COPY: begin
          lo = e0;
          hi = e1;
        end
        MODE_ODD: begin
          lo = sat16(2 * e0 - line_get(vert, fixed, imin(m, last)));
          hi = sat16(2 * e1 - line_get(vert, fixed, imax(last - m, 0)));
        end
        MODE_ZERO: begin
          lo = 0;
          hi = 0;
        end
        MODE_WRAP: begin
          lo = line_get(vert, fixed, imax(last - m + 1, 0));
          hi = line_get(vert, fixed, imin(m - 1, last));
        end
        MODE_REPEAT: begin
          lo = line_get(vert, fixed, imin(m - 1, last));
          hi = line_get(vert, fixed, imax(last - m + 1, 0));
        end
        default: return;
      endcase
      line_put(vert, fixed, -m, lo);
      line_put(vert, fixed, last + m, hi);
    end
    if (mode == MODE_WAVG) begin
      s = line_get(vert, fixed, 0) + line_get(vert, fixed, last);
      s = s >>> 1;
      line_put(vert, fixed, 0, s);
      line_put(vert, fixed, last, s);
    end
  endtask

  task automatic pad_frame();
    int fw, fh, bw;
    fw = eff_fw();
    fh = eff_fh();
    bw = eff_bw();
    if (reg_mode == 3'd0 || reg_axes > AXES_VER || bw == 0) return;
    if (reg_axes == AXES_BOTH || reg_axes == AXES_HOR)
      for (int j = 0; j < fh; j++) pad_line(1'b0, j, fw - 1, bw, reg_mode);
    if (reg_axes == AXES_BOTH)
      for (int j = -bw; j < fw + bw; j++) pad_line(1'b1, j, fh - 1, bw, reg_mode);
    else if (reg_axes == AXES_VER)
      for (int j = 0; j < fw; j++) pad_line(1'b1, j, fh - 1, bw, reg_mode);
  endtask

  task automatic predict_item(logic [1:0] act, int c, int r, int p, output bit has,
                              output pad_result_t res);
    int fw, fh, bw;
    fw = eff_fw();
    fh = eff_fh();
    bw = eff_bw();
    has = 1'b0;
    res.px = '0;
    res.st = ST_RANGE;
    case (act)
      ACT_LOAD: begin
        if (c >= 0 && c < fw && r >= 0 && r < fh) line_put(1'b0, r, c, p);
        else has = 1'b1;
      end
      ACT_APPLY: begin
        pad_frame();
        has = 1'b1;
        res.st = ST_APPLY;
        applies++;
      end
      ACT_READ: begin
        has = 1'b1;
        if (c >= -bw && c < fw + bw && r >= -bw && r < fh + bw) begin
          res.px = line_get(1'b0, r, c);
          res.st = ST_READ;
          reads_checked++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int x;
    if (quiet) return 0;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] act, int c, int r, int p, bit typed = 0,
                           int epx = 0, logic [1:0] est = ST_READ);
    int gap;
    bit has;
    pad_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {6'd0, p[15:0], r[8:0], c[8:0]};
    do @(posedge clk); while (!s_axis_tready);
    predict_item(act, c, r, p, has, res);
    if (act != ACT_NONE) items++;
    if (has) begin
      if (typed) begin
        res.px = epx[15:0];
        res.st = est;
      end
      pending.push_back(res);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] fw, logic [7:0] fh, logic [3:0] bw,
                            logic [2:0] mode, logic [1:0] axes);
    logic [7:0] vals [0:4];
    vals = '{fw, fh, {4'd0, bw}, {5'd0, mode}, {6'd0, axes}};
    settle();
    for (int i = 0; i <= 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    reg_fw = fw;
    reg_fh = fh;
    reg_bw = bw;
    reg_mode = mode;
    reg_axes = axes;
  endtask

  function automatic int rand_pixel();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 7) - 4;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  task automatic noise_item();
    int c, r;
    c = int'($signed(9'($urandom())));
    r = int'($signed(9'($urandom())));
    case ($urandom_range(0, 2))
      0: send_item(ACT_LOAD, c, r, rand_pixel());
      1: send_item(ACT_NONE, c, r, rand_pixel());
      default: if (!(c >= -eff_bw() && c < eff_fw() + eff_bw() && r >= -eff_bw() &&
                     r < eff_fh() + eff_bw()))
        send_item(ACT_READ, c, r, 0);
    endcase
  endtask

  task automatic read_some(int n);
    int c, r, fw, fh, bw;
    fw = eff_fw();
    fh = eff_fh();
    bw = eff_bw();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        noise_item();
      end else begin
        c = $urandom_range(0, fw + 2 * bw - 1) - bw;
        r = $urandom_range(0, fh + 2 * bw - 1) - bw;
        if (!seen[r + OFS][c + OFS]) begin
          c = $urandom_range(0, fw - 1);
          r = $urandom_range(0, fh - 1);
        end
        send_item(ACT_READ, c, r, 0);
      end
    end
  endtask

  task automatic run_phase(logic [7:0] fw, logic [7:0] fh, logic [3:0] bw,
                           logic [2:0] mode, logic [1:0] axes);
    int efw, efh;
    write_regs(fw, fh, bw, mode, axes);
    quiet = ($urandom_range(0, 3) == 0);
    phases++;
    efw = eff_fw();
    efh = eff_fh();
    for (int r = 0; r < efh; r++)
      for (int c = 0; c < efw; c++) begin
        if ($urandom_range(0, 19) == 0) noise_item();
        send_item(ACT_LOAD, c, r, rand_pixel());
      end
    send_item(ACT_APPLY, $urandom_range(0, 20), $urandom_range(0, 20), rand_pixel());
    read_some($urandom_range(8, 20));
    if ($urandom_range(0, 2) == 0) begin
      send_item(ACT_APPLY, 0, 0, 0);
      read_some($urandom_range(4, 10));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    pad_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pixel=%0d status=%0d", $time,
                 $signed(m_axis_tdata), m_axis_tuser);
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata !== want.px) begin
          errors++;
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   $signed(want.px), $signed(m_axis_tdata));
        end
        if (m_axis_tuser !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    errors = 0;
    items = 0;
    reads_checked = 0;
    applies = 0;
    phases = 0;
    results_seen = 0;
    idle_cycles = 0;
    reg_fw = 8'd128;
    reg_fh = 8'd128;
    reg_bw = 4'd1;
    reg_mode = MODE_EVEN;
    reg_axes = AXES_BOTH;
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) begin
        frame_mem[i][j] = '0;
        seen[i][j] = 1'b0;
      end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].act, directed[i].c, directed[i].r, directed[i].p,
                directed[i].typed, directed[i].epx, directed[i].est);

    run_phase(8'd255, 8'd1, 4'd15, MODE_ODD, AXES_BOTH);
    run_phase(8'd1, 8'd200, 4'd8, MODE_WAVG, AXES_BOTH);
    run_phase(8'd0, 8'd0, 4'd3, MODE_REPEAT, AXES_BOTH);
    run_phase(8'd3, 8'd3, 4'd0, MODE_EVEN, AXES_BOTH);
    run_phase(8'd3, 8'd3, 4'd2, 3'd0, AXES_BOTH);
    run_phase(8'd3, 8'd3, 4'd2, MODE_EVEN, 2'd3);
    for (int m = 1; m <= 7; m++)
      for (int a = 0; a <= 2; a++)
        run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  4'($urandom_range(1, 8)), m[2:0], a[1:0]);
    while (items < 1350) begin
      if ($urandom_range(0, 9) == 0)
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 2)),
                  4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  2'($urandom_range(0, 3)));
      else
        run_phase(8'($urandom_range(1, 9)), 8'($urandom_range(1, 9)),
                  4'($urandom_range(1, 8)), 3'($urandom_range(1, 7)),
                  2'($urandom_range(0, 2)));
    end

    quiet = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d items over %0d register settings: %0d applies, %0d in-range reads,",
             items, phases, applies, reads_checked);
    $display("%0d results compared against the padding predictor.", results_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
